### sv/crot_pkg.sv
// shared constants, register codes and atan table for the rotation cordic
package crot_pkg;

  localparam int DATA_WIDTH = 20;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_ITER   = 16;

  localparam int ITER_W    = 5;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;

  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(16);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(39797);

  localparam logic [CFG_IDX_W-1:0] REG_ITERATIONS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INV_GAIN   = CFG_IDX_W'(1);

  // atan(2^-i) scaled by 2^32
  localparam logic [31:0] ATAN_Q32 [32] = '{
    32'd3373259426, 32'd1991351317, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

  // table entry rounded half up to frac fractional bits
  function automatic logic [63:0] atan_entry(input int idx, input int frac);
    logic [63:0] t2;
    t2 = {32'd0, ATAN_Q32[idx % 32]} << 1;
    return ((t2 >> (32 - frac)) + 64'd1) >> 1;
  endfunction

endpackage

### sv/crot_stage.sv
// one micro-rotation pipeline stage with its own valid and ready
module crot_stage #(
  parameter int XW        = 22,
  parameter int ZW        = 22,
  parameter int SHIFT     = 0,
  parameter int FRAC_BITS = crot_pkg::FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 active,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [XW-1:0] x_up,
  input  logic signed [XW-1:0] y_up,
  input  logic signed [ZW-1:0] z_up,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [XW-1:0] x_dn,
  output logic signed [XW-1:0] y_dn,
  output logic signed [ZW-1:0] z_dn
);

  localparam logic signed [ZW-1:0] ATAN = ZW'(crot_pkg::atan_entry(SHIFT, FRAC_BITS));

  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ZW-1:0] z_next;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;

  assign up_ready = !dn_valid || dn_ready;
  assign dx = y_up >>> SHIFT;
  assign dy = x_up >>> SHIFT;

  always_comb begin
    x_next = x_up;
    y_next = y_up;
    z_next = z_up;
    if (active) begin
      if (!z_up[ZW-1]) begin
        x_next = x_up - dx;
        y_next = y_up + dy;
        z_next = z_up - ATAN;
      end else begin
        x_next = x_up + dx;
        y_next = y_up - dy;
        z_next = z_up + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_dn <= x_next;
      y_dn <= y_next;
      z_dn <= z_next;
    end
  end

endmodule

### sv/crot_scale.sv
// gain multiply stage followed by round and saturate stage
module crot_scale #(
  parameter int DW = crot_pkg::DATA_WIDTH,
  parameter int XW = 22,
  parameter int ZW = 22
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [crot_pkg::GAIN_W-1:0]      gain,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  logic signed [XW-1:0]             x_up,
  input  logic signed [XW-1:0]             y_up,
  input  logic signed [ZW-1:0]             z_up,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output logic signed [DW-1:0]             x_dn,
  output logic signed [DW-1:0]             y_dn,
  output logic signed [DW-1:0]             z_dn
);

  localparam int GW = crot_pkg::GAIN_W + 1;
  localparam int PW = XW + GW;
  localparam int RW = PW + 1;
  localparam logic signed [RW-1:0] HALF = RW'(1) <<< (crot_pkg::GAIN_FRAC - 1);
  localparam logic signed [RW-1:0] HI = RW'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [RW-1:0] LO = ~HI;
  localparam logic signed [ZW:0]   ZHI = (ZW+1)'({1'b0, {(DW-1){1'b1}}});
  localparam logic signed [ZW:0]   ZLO = ~ZHI;

  logic                 mul_valid;
  logic                 mul_ready;
  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;
  logic signed [ZW-1:0] pz;
  logic signed [GW-1:0] g;
  logic signed [RW-1:0] rx;
  logic signed [RW-1:0] ry;
  logic signed [ZW:0]   zw;
  logic signed [DW-1:0] x_next;
  logic signed [DW-1:0] y_next;
  logic signed [DW-1:0] z_next;

  assign g = $signed({1'b0, gain});
  assign mul_ready = !dn_valid || dn_ready;
  assign up_ready  = !mul_valid || mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (up_ready) begin
      mul_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      px <= PW'(x_up) * PW'(g);
      py <= PW'(y_up) * PW'(g);
      pz <= z_up;
    end
  end

  // round to nearest, ties up, then drop the gain fraction
  assign rx = (RW'(px) + HALF) >>> crot_pkg::GAIN_FRAC;
  assign ry = (RW'(py) + HALF) >>> crot_pkg::GAIN_FRAC;
  assign zw = (ZW+1)'(pz);

  always_comb begin
    if (rx > HI) begin
      x_next = DW'(HI);
    end else if (rx < LO) begin
      x_next = DW'(LO);
    end else begin
      x_next = DW'(rx);
    end
    if (ry > HI) begin
      y_next = DW'(HI);
    end else if (ry < LO) begin
      y_next = DW'(LO);
    end else begin
      y_next = DW'(ry);
    end
    if (zw > ZHI) begin
      z_next = DW'(ZHI);
    end else if (zw < ZLO) begin
      z_next = DW'(ZLO);
    end else begin
      z_next = DW'(zw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (mul_ready) begin
      dn_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && mul_valid) begin
      x_dn <= x_next;
      y_dn <= y_next;
      z_dn <= z_next;
    end
  end

endmodule

### sv/cordic_rotation.sv
// Circular rotation-mode cordic, signed fixed point with FRAC_BITS fraction bits.
// Each beat carries x, y and an angle z in radians; the block runs one
// micro-rotation per pipeline stage (MAX_ITER stages, those at or beyond the
// iterations register pass the item through unchanged), then a stage that
// multiplies x and y by inv_gain and a stage that rounds and saturates all three.
// A new beat is taken every cycle unless the pipe stalls. Every stage holds its
// own valid bit and stalls only when full, so a stalled output fills the pipe
// before in_ready drops. Registers are written through the cfg channel (always
// ready) and should change only while the pipe is empty.
module cordic_rotation #(
  parameter int DATA_WIDTH = crot_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = crot_pkg::FRAC_BITS,
  parameter int MAX_ITER   = crot_pkg::MAX_ITER
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crot_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crot_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [DATA_WIDTH-1:0]        x_in,
  input  logic signed [DATA_WIDTH-1:0]        y_in,
  input  logic signed [DATA_WIDTH-1:0]        z_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [DATA_WIDTH-1:0]        x_out,
  output logic signed [DATA_WIDTH-1:0]        y_out,
  output logic signed [DATA_WIDTH-1:0]        z_out
);

  localparam int XW = DATA_WIDTH + 2;
  localparam int ZW = (DATA_WIDTH > FRAC_BITS + 2) ? DATA_WIDTH + 2 : FRAC_BITS + 4;

  logic [crot_pkg::ITER_W-1:0] iterations;
  logic [crot_pkg::GAIN_W-1:0] inv_gain;

  logic [MAX_ITER:0]    vld;
  logic [MAX_ITER:0]    rdy;
  logic signed [XW-1:0] xs [MAX_ITER+1];
  logic signed [XW-1:0] ys [MAX_ITER+1];
  logic signed [ZW-1:0] zs [MAX_ITER+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iterations <= crot_pkg::ITER_RESET;
      inv_gain   <= crot_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crot_pkg::REG_ITERATIONS: iterations <= cfg_data[crot_pkg::ITER_W-1:0];
        crot_pkg::REG_INV_GAIN:   inv_gain   <= cfg_data[crot_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign vld[0]   = in_valid;
  assign in_ready = rdy[0];
  assign xs[0]    = XW'(x_in);
  assign ys[0]    = XW'(y_in);
  assign zs[0]    = ZW'(z_in);

  for (genvar i = 0; i < MAX_ITER; i++) begin : g_stage
    crot_stage #(
      .XW       (XW),
      .ZW       (ZW),
      .SHIFT    (i),
      .FRAC_BITS(FRAC_BITS)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .active  (crot_pkg::ITER_W'(i) < iterations),
      .up_valid(vld[i]),
      .up_ready(rdy[i]),
      .x_up    (xs[i]),
      .y_up    (ys[i]),
      .z_up    (zs[i]),
      .dn_valid(vld[i+1]),
      .dn_ready(rdy[i+1]),
      .x_dn    (xs[i+1]),
      .y_dn    (ys[i+1]),
      .z_dn    (zs[i+1])
    );
  end

  crot_scale #(
    .DW(DATA_WIDTH),
    .XW(XW),
    .ZW(ZW)
  ) u_scale (
    .clk     (clk),
    .rst     (rst),
    .gain    (inv_gain),
    .up_valid(vld[MAX_ITER]),
    .up_ready(rdy[MAX_ITER]),
    .x_up    (xs[MAX_ITER]),
    .y_up    (ys[MAX_ITER]),
    .z_up    (zs[MAX_ITER]),
    .dn_valid(out_valid),
    .dn_ready(out_ready),
    .x_dn    (x_out),
    .y_dn    (y_out),
    .z_dn    (z_out)
  );

`ifndef NO_ASSERTIONS
  // an empty rotation pipe always takes a beat
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (vld[MAX_ITER:1] == '0) |-> in_ready)
    else $error("rotation pipe empty but in_ready low");

  // a stalled last rotation stage keeps its beat
  a_last_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[MAX_ITER] && !rdy[MAX_ITER]) |=> (vld[MAX_ITER] && $stable(xs[MAX_ITER])
      && $stable(zs[MAX_ITER])))
    else $error("stalled rotation stage lost its beat");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && vld[MAX_ITER:1] == '0))
    else $error("valid bits set after reset");

  // the input side only stalls when the first stage is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> vld[1])
    else $error("in_ready low with first stage empty");
`endif

endmodule
